// File: design/bcc_pkg.sv
// Shared types and constants for the button click classifier.
package bcc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgTimeW = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 40;  // pin_level + now_ms, padded to bytes
  localparam int unsigned OutDataW = 8;   // five event flags, padded to a byte

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE       = 3'd0,
    REG_ACTIVE_LOW   = 3'd1,
    REG_DEBOUNCE     = 3'd2,
    REG_LONG_PRESS   = 3'd3,
    REG_DOUBLE_CLICK = 3'd4
  } cfg_reg_e;

  localparam logic [CfgTimeW-1:0] DebounceRst    = 16'd40;
  localparam logic [CfgTimeW-1:0] LongPressRst   = 16'd1000;
  localparam logic [CfgTimeW-1:0] DoubleClickRst = 16'd300;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_PRESSED     = 2'd1,
    PH_WAIT_DOUBLE = 2'd2
  } phase_e;

  typedef struct packed {
    logic                enable;
    logic                active_low;
    logic [CfgTimeW-1:0] debounce_time;
    logic [CfgTimeW-1:0] long_press_time;
    logic [CfgTimeW-1:0] double_click_window;
  } cfg_t;

  typedef struct packed {
    logic double_click;
    logic single_click;
    logic long_press;
    logic release_ev;
    logic press;
  } events_t;

endpackage

// File: design/bcc_core.sv
// Debounce and click classification state with its per-poll update.
module bcc_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  bcc_pkg::cfg_t                cfg_i,
  input  logic                         pin_level_i,
  input  logic [bcc_pkg::TimeW-1:0]    now_ms_i,
  output bcc_pkg::events_t             events_o
);
  import bcc_pkg::*;

  logic             last_raw_q, last_raw_d;
  logic [TimeW-1:0] raw_change_time_q, raw_change_time_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic [TimeW-1:0] release_time_q, release_time_d;
  logic             long_done_q, long_done_d;
  logic             one_pending_q, one_pending_d;
  phase_e           phase_q, phase_d;

  logic             raw;
  logic [TimeW-1:0] since_raw, since_press, since_release;

  always_comb begin
    last_raw_d        = last_raw_q;
    raw_change_time_d = raw_change_time_q;
    stable_d          = stable_q;
    press_time_d      = press_time_q;
    release_time_d    = release_time_q;
    long_done_d       = long_done_q;
    one_pending_d     = one_pending_q;
    phase_d           = phase_q;
    events_o          = '0;

    raw           = cfg_i.active_low ? ~pin_level_i : pin_level_i;
    since_raw     = '0;
    since_press   = now_ms_i - press_time_q;
    since_release = '0;

    if (cfg_i.enable) begin
      if (raw != last_raw_q) begin
        last_raw_d        = raw;
        raw_change_time_d = now_ms_i;
      end
      since_raw = now_ms_i - raw_change_time_d;

      // Accept a raw change once it has held for the debounce time
      if ((last_raw_d != stable_q) &&
          (since_raw >= {{(TimeW-CfgTimeW){1'b0}}, cfg_i.debounce_time})) begin
        stable_d = last_raw_d;
        if (last_raw_d) begin
          press_time_d    = now_ms_i;
          long_done_d     = 1'b0;
          phase_d         = PH_PRESSED;
          events_o.press  = 1'b1;
        end else begin
          events_o.release_ev = 1'b1;
          if (long_done_q) begin
            long_done_d   = 1'b0;
            one_pending_d = 1'b0;
            phase_d       = PH_IDLE;
          end else if (one_pending_q) begin
            one_pending_d         = 1'b0;
            phase_d               = PH_IDLE;
            events_o.double_click = 1'b1;
          end else begin
            one_pending_d  = 1'b1;
            phase_d        = PH_WAIT_DOUBLE;
            release_time_d = now_ms_i;
          end
        end
      end

      since_press   = now_ms_i - press_time_d;
      since_release = now_ms_i - release_time_d;

      case (phase_d)
        PH_PRESSED: begin
          if (!long_done_d &&
              (since_press >= {{(TimeW-CfgTimeW){1'b0}}, cfg_i.long_press_time})) begin
            long_done_d         = 1'b1;
            events_o.long_press = 1'b1;
          end
        end
        PH_WAIT_DOUBLE: begin
          if (since_release >= {{(TimeW-CfgTimeW){1'b0}}, cfg_i.double_click_window}) begin
            phase_d               = PH_IDLE;
            one_pending_d         = 1'b0;
            events_o.single_click = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q        <= 1'b0;
      raw_change_time_q <= '0;
      stable_q          <= 1'b0;
      press_time_q      <= '0;
      release_time_q    <= '0;
      long_done_q       <= 1'b0;
      one_pending_q     <= 1'b0;
      phase_q           <= PH_IDLE;
    end else if (step_i) begin
      last_raw_q        <= last_raw_d;
      raw_change_time_q <= raw_change_time_d;
      stable_q          <= stable_d;
      press_time_q      <= press_time_d;
      release_time_q    <= release_time_d;
      long_done_q       <= long_done_d;
      one_pending_q     <= one_pending_d;
      phase_q           <= phase_d;
    end
  end

endmodule

// File: design/button_click_classifier_unit.sv
// Top level of the button click classifier: stream ports, config and pipeline registers.
//
// Usage
//   s_axis carries one poll per transaction: the raw pin level and a 32-bit
//   millisecond timestamp. m_axis returns exactly one result per poll with
//   five event flags (press, release, long press, single click, double click).
//   The cfg port writes one register per cycle while cfg_we_i is high:
//   0 enable, 1 active_low, 2 debounce_time, 3 long_press_time,
//   4 double_click_window. Other indexes are ignored. Write only while idle.
// Timing
//   A poll is captured in the input register and classified on its way into
//   the output register: tvalid rises at the edge that moves it there.
//   One poll per cycle is sustained while m_axis_tready_i stays high; the single
//   classification pass between the input and output registers sets that figure.
// Reset
//   rst_ni clears all button state, empties both registers and loads the
//   register defaults (disabled, active low, 40 / 1000 / 300 ms).
// Stall
//   While m_axis_tready_i is low the result holds; one more poll is still
//   taken into the input register, after which s_axis_tready_o drops.
module button_click_classifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Poll input; tdata from bit 0: pin_level [0], now_ms [32:1], zero pad [39:33]
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [bcc_pkg::InDataW-1:0]    s_axis_tdata_i,
  // Result output; tdata from bit 0: press_event, release_event,
  // long_press_event, single_click_event, double_click_event, zero pad [7:5]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [bcc_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import bcc_pkg::*;

  cfg_t             cfg_q;

  logic             in_valid_q;
  logic             in_pin_q;
  logic [TimeW-1:0] in_now_q;

  logic             out_valid_q;
  events_t          out_ev_q;
  events_t          ev;

  logic             fire;

  // Advance the input register into the output register when the output is
  // empty or drained in this cycle.
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable              <= 1'b0;
      cfg_q.active_low          <= 1'b1;
      cfg_q.debounce_time       <= DebounceRst;
      cfg_q.long_press_time     <= LongPressRst;
      cfg_q.double_click_window <= DoubleClickRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:       cfg_q.enable              <= cfg_wdata_i[0];
        REG_ACTIVE_LOW:   cfg_q.active_low          <= cfg_wdata_i[0];
        REG_DEBOUNCE:     cfg_q.debounce_time       <= cfg_wdata_i[CfgTimeW-1:0];
        REG_LONG_PRESS:   cfg_q.long_press_time     <= cfg_wdata_i[CfgTimeW-1:0];
        REG_DOUBLE_CLICK: cfg_q.double_click_window <= cfg_wdata_i[CfgTimeW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the poll until it is classified
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_pin_q <= s_axis_tdata_i[0];
      in_now_q <= s_axis_tdata_i[TimeW:1];
    end
  end

  // State update happens only when the poll moves to the output register
  bcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .cfg_i       (cfg_q),
    .pin_level_i (in_pin_q),
    .now_ms_i    (in_now_q),
    .events_o    (ev)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_ev_q <= ev;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-5){1'b0}}, out_ev_q.double_click,
                            out_ev_q.single_click, out_ev_q.long_press,
                            out_ev_q.release_ev, out_ev_q.press};

  // Assertions

  // A single debounced edge per poll: never press and release together
  a_press_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("press and release in one result");

  // Long press needs the pressed phase, single click the waiting phase
  a_long_single_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[2] && m_axis_tdata_o[3]))
    else $error("long press and single click in one result");

  // A double click closes the window, so no single click beside it
  a_single_double_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[3] && m_axis_tdata_o[4]))
    else $error("single and double click in one result");

  // Back-pressure only when both registers are full and the receiver stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without a full pipeline");

  // A stalled result must not be replaced
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_ev_q)))
    else $error("stalled result changed");

endmodule

// File: tb/bcc_event_checker.sv
// Checker for the button click classifier: predicts each poll's events and compares results.
module bcc_event_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  input  logic                           s_axis_tready_i,
  // pin_level [0], now_ms [32:1], zero pad [39:33]
  input  logic [bcc_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                           m_axis_tvalid_i,
  input  logic                           m_axis_tready_i,
  // press, release, long press, single click, double click, zero pad [7:5]
  input  logic [bcc_pkg::OutDataW-1:0]   m_axis_tdata_i,
  output int unsigned                    pending_o,
  output int unsigned                    mismatches_o,
  // per event kind, in tdata bit order
  output logic [4:0][31:0]               event_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bcc_pkg::*;

  localparam int unsigned MaxShown = 10;

  cfg_t             cfg;
  logic             last_raw;
  logic             stable;
  logic             long_done;
  logic             click_pending;
  logic [TimeW-1:0] raw_change_t;
  logic [TimeW-1:0] press_t;
  logic [TimeW-1:0] release_t;
  phase_e           ph;

  events_t          expected_events_q[$];
  events_t          got;
  events_t          want;
  int unsigned      mism;
  int unsigned      results_seen;
  logic [4:0][31:0] hits;

  function automatic events_t classify_poll(input logic level, input logic [TimeW-1:0] now);
    events_t          ev;
    logic             raw;
    logic [TimeW-1:0] elapsed;
    ev = '0;
    if (cfg.enable) begin
      raw = cfg.active_low ? ~level : level;
      if (raw != last_raw) begin
        last_raw     = raw;
        raw_change_t = now;
      end
      elapsed = now - raw_change_t;
      if (last_raw != stable && elapsed >= TimeW'(cfg.debounce_time)) begin
        stable = last_raw;
        if (stable) begin
          press_t   = now;
          long_done = 1'b0;
          ph        = PH_PRESSED;
          ev.press  = 1'b1;
        end else begin
          ev.release_ev = 1'b1;
          if (long_done) begin
            // a long press swallows its click
            long_done     = 1'b0;
            click_pending = 1'b0;
            ph            = PH_IDLE;
          end else if (click_pending) begin
            click_pending   = 1'b0;
            ph              = PH_IDLE;
            ev.double_click = 1'b1;
          end else begin
            click_pending = 1'b1;
            ph            = PH_WAIT_DOUBLE;
            release_t     = now;
          end
        end
      end
      elapsed = now - press_t;
      if (ph == PH_PRESSED && !long_done && elapsed >= TimeW'(cfg.long_press_time)) begin
        long_done     = 1'b1;
        ev.long_press = 1'b1;
      end
      elapsed = now - release_t;
      if (ph == PH_WAIT_DOUBLE && elapsed >= TimeW'(cfg.double_click_window)) begin
        ph              = PH_IDLE;
        click_pending   = 1'b0;
        ev.single_click = 1'b1;
      end
    end
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg           = '{enable: 1'b0, active_low: 1'b1, debounce_time: DebounceRst,
                        long_press_time: LongPressRst, double_click_window: DoubleClickRst};
      last_raw      = 1'b0;
      stable        = 1'b0;
      long_done     = 1'b0;
      click_pending = 1'b0;
      raw_change_t  = '0;
      press_t       = '0;
      release_t     = '0;
      ph            = PH_IDLE;
      expected_events_q.delete();
      mism          = 0;
      results_seen  = 0;
      hits          = '0;
      pending_o    <= 0;
      mismatches_o <= 0;
      event_hits_o <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE:       cfg.enable              = cfg_wdata_i[0];
          REG_ACTIVE_LOW:   cfg.active_low          = cfg_wdata_i[0];
          REG_DEBOUNCE:     cfg.debounce_time       = cfg_wdata_i[CfgTimeW-1:0];
          REG_LONG_PRESS:   cfg.long_press_time     = cfg_wdata_i[CfgTimeW-1:0];
          REG_DOUBLE_CLICK: cfg.double_click_window = cfg_wdata_i[CfgTimeW-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_events_q.push_back(classify_poll(s_axis_tdata_i[0],
                                                  s_axis_tdata_i[TimeW:1]));
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        results_seen++;
        got = events_t'(m_axis_tdata_i[4:0]);
        if (expected_events_q.size() == 0) begin
          mism++;
          if (mism <= MaxShown) begin
            $display("[%0t] result %0d arrived with no poll outstanding: tdata %b",
                     $realtime, results_seen, m_axis_tdata_i);
          end
        end else begin
          want = expected_events_q.pop_front();
          hits[0] += want.press;
          hits[1] += want.release_ev;
          hits[2] += want.long_press;
          hits[3] += want.single_click;
          hits[4] += want.double_click;
          if (got.press !== want.press || got.release_ev !== want.release_ev ||
              got.long_press !== want.long_press || got.single_click !== want.single_click ||
              got.double_click !== want.double_click || m_axis_tdata_i[7:5] !== 3'b000) begin
            mism++;
            if (mism <= MaxShown) begin
              $display("[%0t] result %0d mismatch (exp/got): press %b/%b release %b/%b",
                       $realtime, results_seen, want.press, got.press,
                       want.release_ev, got.release_ev);
              $display("    long %b/%b single %b/%b double %b/%b pad 000/%b",
                       want.long_press, got.long_press, want.single_click, got.single_click,
                       want.double_click, got.double_click, m_axis_tdata_i[7:5]);
            end
          end
        end
      end

      pending_o    <= expected_events_q.size();
      mismatches_o <= mism;
      event_hits_o <= hits;
    end
  end

endmodule

// File: tb/button_click_classifier_unit_tb.sv
// Testbench top for the button click classifier: stimulus, handshake pacing and verdict.
module button_click_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcc_pkg::*;

  localparam int unsigned NumRegs     = 5;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 203;
  localparam int unsigned MaxGap      = 14;
  localparam int unsigned CycleLimit  = 400000;
  // Directed polls start just below the 32-bit wrap so elapsed times cross zero
  localparam logic [TimeW-1:0] WrapBase = 32'hFFFF_FF00;

  logic                clk_i     = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned      pending;
  int unsigned      mismatches;
  logic [4:0][31:0] event_hits;

  // Stimulus-side view of the settings, used only to shape poll timing and pin levels
  bit          cur_al = 1'b1;
  int unsigned cur_deb;
  int unsigned cur_long;
  int unsigned cur_win;

  bit          gaps_on = 1'b1;
  int unsigned polls_sent = 0;
  int unsigned pause_at = 32'hFFFF_FFFF;
  int unsigned settings_loaded = 0;
  int unsigned cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  button_click_classifier_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  bcc_event_checker u_event_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .pending_o       (pending),
    .mismatches_o    (mismatches),
    .event_hits_o    (event_hits)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: after each transaction, drop tready for a random stretch,
  // or keep it high when gaps are off so results drain back to back.
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk_i);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_tvalid) begin
        stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
        if (stall != 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Hold until every accepted poll has produced its result.
  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Idle the input side, drain, and give the two-stage pipeline time to empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
  endtask

  // One poll transaction. Draw a gap first; at the chosen item, hold off
  // until the block has nothing in flight.
  task automatic send_poll(input logic level, input logic [TimeW-1:0] now);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (polls_sent == pause_at || gap != 0) s_tvalid <= 1'b0;
    if (polls_sent == pause_at) wait_drained();
    repeat (gap) @(posedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW - TimeW - 1){1'b0}}, now, level};
    do @(posedge clk_i); while (!s_tready);
    polls_sent++;
  endtask

  // Write one register; the caller lowers the write enable after the burst.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  // Load all five registers. Single-bit registers get random upper bits that
  // must be masked off, and a stray write past the last index must be ignored.
  task automatic load_settings(input bit en, input bit al, input logic [CfgTimeW-1:0] deb,
                               input logic [CfgTimeW-1:0] lp, input logic [CfgTimeW-1:0] win);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    write_reg(REG_ENABLE, {junk[CfgDataW-1:1], en});
    write_reg(REG_ACTIVE_LOW, {~junk[CfgDataW-1:1], al});
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_DOUBLE_CLICK, win);
    write_reg(CfgIdxW'(NumRegs + $urandom_range(0, 2)), junk);
    cfg_we   <= 1'b0;
    cur_al   = al;
    cur_deb  = deb;
    cur_long = lp;
    cur_win  = win;
    settings_loaded++;
  endtask

  // Mostly mid-range times, with zero and full scale mixed in.
  function automatic logic [CfgTimeW-1:0] pick_time(input int unsigned typical);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CfgTimeW'($urandom_range(0, typical));
  endfunction

  function automatic logic pin_for(input bit pressed);
    return pressed ^ cur_al;
  endfunction

  // Realistic button use: alternate pressed and released holds whose length
  // lands either side of the long-press or double-click threshold, with
  // contact bounce at each edge, some raw-level noise and rare clock jumps.
  task automatic run_sessions(input int unsigned count);
    bit               held;
    int unsigned      start;
    int unsigned      step_max;
    int unsigned      base;
    int unsigned      target;
    int unsigned      spent;
    int unsigned      step;
    int unsigned      bounces;
    int unsigned      r;
    logic             lvl;
    logic [TimeW-1:0] now;
    held     = 1'b0;
    start    = polls_sent;
    now      = $urandom();
    step_max = (cur_deb + cur_long + cur_win) / 30 + 2;
    pause_at = polls_sent + $urandom_range(count / 4, 3 * count / 4);
    while (polls_sent - start < count) begin
      held   = !held;
      base   = held ? cur_long : cur_win;
      target = cur_deb + ($urandom_range(0, 1) ? $urandom_range(0, base)
                                               : base + $urandom_range(1, base + 100));
      bounces = $urandom_range(0, 3);
      for (int k = 0; k < bounces; k++) begin
        now += $urandom_range(0, cur_deb / 2 + 1);
        send_poll(pin_for(held ^ k[0]), now);
      end
      spent = 0;
      do begin
        step  = $urandom_range(0, step_max);
        now  += step;
        spent += step;
        r     = $urandom_range(0, 99);
        lvl   = (r < 6) ? 1'($urandom_range(0, 1)) : pin_for(held);
        if (r == 99) now = $urandom();
        send_poll(lvl, now);
      end while (spent < target && polls_sent - start < count);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Disabled after reset: polls at both time extremes must yield no events.
    send_poll(1'b0, '0);
    send_poll(1'b1, '1);
    settle();

    // Default times, active low. Walk through bounce, single click, double
    // click, long press and a window expiry, crossing the 32-bit wrap.
    load_settings(1'b1, 1'b1, DebounceRst, LongPressRst, DoubleClickRst);
    send_poll(1'b0, WrapBase);
    send_poll(1'b1, WrapBase + 10);    // bounce back before debounce
    send_poll(1'b0, WrapBase + 20);
    send_poll(1'b0, WrapBase + 60);    // press
    send_poll(1'b1, WrapBase + 100);
    send_poll(1'b1, WrapBase + 140);   // release opens the window
    send_poll(1'b0, WrapBase + 200);
    send_poll(1'b0, WrapBase + 240);
    send_poll(1'b1, WrapBase + 300);
    send_poll(1'b1, WrapBase + 340);   // second release: double click, past the wrap
    send_poll(1'b0, WrapBase + 400);
    send_poll(1'b0, WrapBase + 440);
    send_poll(1'b0, WrapBase + 1440);  // long press fires
    send_poll(1'b1, WrapBase + 1500);
    send_poll(1'b1, WrapBase + 1540);  // release after long press: no click
    send_poll(1'b0, WrapBase + 1600);
    send_poll(1'b0, WrapBase + 1640);
    send_poll(1'b1, WrapBase + 1700);
    send_poll(1'b1, WrapBase + 1740);
    send_poll(1'b1, WrapBase + 2040);  // window expires: single click
    settle();

    // Zero times, active high: press and long press coincide, then release.
    load_settings(1'b1, 1'b0, '0, '0, '0);
    send_poll(1'b1, '0);
    send_poll(1'b0, 32'd1);
    settle();

    // Zero window with the longest hold time: release and single click coincide.
    load_settings(1'b1, 1'b0, '0, '1, '0);
    send_poll(1'b1, 32'd2);
    send_poll(1'b0, 32'd3);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      // Every fourth phase runs both sides back to back.
      gaps_on = (p % 4 != 3);
      case (p)
        0:       load_settings(1'b1, 1'($urandom_range(0, 1)), '1, '1, '1);
        1:       load_settings(1'b1, 1'($urandom_range(0, 1)), '0, '0, '0);
        default: load_settings(1'b1, 1'($urandom_range(0, 1)), pick_time(80),
                               pick_time(1500), pick_time(600));
      endcase
      run_sessions(PhaseItems);
      if (p == 4) begin
        // Disabled mid-run: state must hold across these polls.
        settle();
        load_settings(1'b0, cur_al, CfgTimeW'(cur_deb), CfgTimeW'(cur_long),
                      CfgTimeW'(cur_win));
        repeat (20) send_poll(1'($urandom_range(0, 1)), $urandom());
      end
    end
    settle();

    $display("Sent %0d polls under %0d register settings, with and without handshake gaps.",
             polls_sent, settings_loaded);
    $display("Events predicted: press %0d, release %0d, long %0d, single %0d, double %0d.",
             event_hits[0], event_hits[1], event_hits[2], event_hits[3], event_hits[4]);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatching results, %0d still outstanding", mismatches, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/bcc_pkg.sv
design/bcc_core.sv
design/button_click_classifier_unit.sv
tb/bcc_event_checker.sv
tb/button_click_classifier_unit_tb.sv
